[rtl/vfc_pkg.sv]
// Shared types, register map and field widths of the view frustum corner block.
`default_nettype none
package vfc_pkg;
  localparam int unsigned FOV_W        = 16;
  localparam int unsigned DIST_W       = 20;
  localparam int unsigned ASP_W        = 16;
  localparam int unsigned VEC_W        = 16;
  localparam int unsigned POS_W        = 21;
  localparam int unsigned TAN_W        = 32;
  localparam int unsigned HALF_W       = 36;
  localparam int unsigned WIDE_W       = 40;
  localparam int unsigned CEN_W        = 21;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 63;
  localparam int unsigned IN_TDATA_W   = 56;
  localparam int unsigned OUT_TUSER_W  = 5;
  localparam int unsigned COORD_BITS_DEF = 21;
  localparam int unsigned TAN_DEPTH_DEF  = 1024;

  localparam logic [IDX_W-1:0] POINT_CENTER = 4'd0;
  localparam logic [IDX_W-1:0] POINT_LAST   = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSITION,
    CFG_FORWARD,
    CFG_UP,
    CFG_LEFT,
    CFG_DEF_FOV,
    CFG_DEF_NEAR,
    CFG_DEF_FAR,
    CFG_ASPECT
  } cfg_index_t;

  typedef struct packed {
    logic [62:0]       position;
    logic [47:0]       forward;
    logic [47:0]       up;
    logic [47:0]       left;
    logic [FOV_W-1:0]  def_fov;
    logic [DIST_W-1:0] def_near;
    logic [DIST_W-1:0] def_far;
    logic [ASP_W-1:0]  aspect;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    position: 63'd0,
    forward:  48'd16384,
    up:       48'd1073741824,
    left:     48'd70368744177664,
    def_fov:  16'd11520,
    def_near: 20'd26,
    def_far:  20'd25600,
    aspect:   16'd5461
  };

  typedef struct packed {
    logic              model;
    logic [CEN_W-1:0]  dist_center;
    logic [DIST_W-1:0] dist_near;
    logic [DIST_W-1:0] dist_far;
    logic [HALF_W-1:0] half_h_near;
    logic [HALF_W-1:0] half_h_far;
    logic [WIDE_W-1:0] half_w_near;
    logic [WIDE_W-1:0] half_w_far;
  } frustum_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;
endpackage
`default_nettype wire

[rtl/view_frustum_corners.sv]
// Top level: configuration registers, front pipeline, request queue and point generator.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata fov,near,far; s_tuser model_space
//  m_      | out | m_tvalid/m_tready  | m_tdata x,y,z; m_tuser index,saturated; m_tlast
//  cfg_    | in  | cfg_wen            | cfg_addr register, cfg_wdata value
//
// Nine output beats per request, one per cycle while m_tready stays high;
// the single point walker in the back end sets that rate.
// The front pipeline takes a request every cycle until the
// two-entry queue fills. Reset is synchronous; the tangent table needs no fill.
// Output stalls hold the back end only; the front keeps working into the queue.
`default_nettype none
module view_frustum_corners #(
  parameter int unsigned COORD_BITS      = vfc_pkg::COORD_BITS_DEF,
  parameter int unsigned TAN_TABLE_DEPTH = vfc_pkg::TAN_DEPTH_DEF,
  localparam int unsigned OUT_TDATA_W    = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [vfc_pkg::IN_TDATA_W-1:0]     s_tdata,   // fov_request, near_request, far_request
  input  logic                               s_tuser,   // model_space
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [OUT_TDATA_W-1:0]             m_tdata,   // point_x, point_y, point_z, zero fill
  output logic [vfc_pkg::OUT_TUSER_W-1:0]    m_tuser,   // point_index, saturated
  output logic                               m_tlast,
  input  logic                               cfg_wen,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [vfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import vfc_pkg::*;

  cfg_t       cfg;
  logic       q_push, q_pop;
  frustum_t   q_in, q_head;
  q_status_t  q_status;
  logic [IDX_W-1:0] point_index;
  logic signed [COORD_BITS-1:0] point_x, point_y, point_z;
  logic       saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index_t'(cfg_addr))
        CFG_POSITION: cfg.position <= cfg_wdata;
        CFG_FORWARD:  cfg.forward  <= cfg_wdata[47:0];
        CFG_UP:       cfg.up       <= cfg_wdata[47:0];
        CFG_LEFT:     cfg.left     <= cfg_wdata[47:0];
        CFG_DEF_FOV:  cfg.def_fov  <= cfg_wdata[FOV_W-1:0];
        CFG_DEF_NEAR: cfg.def_near <= cfg_wdata[DIST_W-1:0];
        CFG_DEF_FAR:  cfg.def_far  <= cfg_wdata[DIST_W-1:0];
        CFG_ASPECT:   cfg.aspect   <= cfg_wdata[ASP_W-1:0];
        default:      cfg          <= cfg;
      endcase
    end
  end

  vfc_front #(.TAN_TABLE_DEPTH(TAN_TABLE_DEPTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .fov_request  (s_tdata[15:0]),
    .near_request (s_tdata[35:16]),
    .far_request  (s_tdata[55:36]),
    .model_space  (s_tuser),
    .cfg          (cfg),
    .q_status     (q_status),
    .push         (q_push),
    .push_data    (q_in)
  );

  vfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  vfc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_status    (q_status),
    .pop         (q_pop),
    .cfg         (cfg),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .saturated   (saturated),
    .last_point  (m_tlast)
  );

  assign m_tdata = OUT_TDATA_W'({point_z, point_y, point_x});
  assign m_tuser = {saturated, point_index};

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (point_index == POINT_LAST)))
    else $error("tlast does not match the final point");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("push into full request queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("pop from empty request queue");
endmodule
`default_nettype wire

[rtl/vfc_tan_rom.sv]
// Tangent table, built at elaboration by integer rotation, two registered read ports.
`default_nettype none
module vfc_tan_rom #(
  parameter int unsigned DEPTH = vfc_pkg::TAN_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr_lo,
  input  logic [AW-1:0] addr_hi,
  output logic [31:0]   data_lo,
  output logic [31:0]   data_hi
);
  import vfc_pkg::*;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] SAT     = 64'hFFFF_FFFF;
  localparam logic [63:0] X1      = PI_Q30 / (64'd2 * 64'(DEPTH));
  localparam logic [63:0] X2      = (X1 * X1) >> 30;
  localparam logic [63:0] X3      = (X2 * X1) >> 30;
  localparam logic [63:0] X4      = (X2 * X2) >> 30;
  localparam logic [63:0] X5      = (X4 * X1) >> 30;
  localparam logic [63:0] X6      = (X4 * X2) >> 30;
  localparam logic [63:0] SN      = X1 - X3 / 64'd6 + X5 / 64'd120;
  localparam logic [63:0] CS      = ONE_Q30 - X2 / 64'd2 + X4 / 64'd24 - X6 / 64'd720;

  typedef logic [31:0] tbl_t [0:DEPTH];

  // shift and subtract quotient
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tbl_t build_tbl();
    tbl_t        tbl;
    logic [63:0] c, s, t, a, b;
    c  = ONE_Q30;
    s  = 64'd0;
    for (int k = 0; k < int'(DEPTH); k++) begin
      t = SAT;
      if (c != 64'd0) begin
        t = udiv((s << 16) + (c >> 1), c);
        if (t > SAT) t = SAT;
      end
      tbl[k] = t[31:0];
      a = c * CS;
      b = s * SN;
      s = (s * CS + c * SN) >> 30;
      c = (a > b) ? ((a - b) >> 30) : 64'd0;
    end
    tbl[DEPTH] = SAT[31:0];
    return tbl;
  endfunction

  localparam tbl_t TBL = build_tbl();

  always_ff @(posedge clk) begin
    if (en) begin
      data_lo <= TBL[addr_lo];
      data_hi <= TBL[addr_hi];
    end
  end
endmodule
`default_nettype wire

[rtl/vfc_front.sv]
// Front pipeline: resolve defaults, tangent lookup and interpolation, half extents.
`default_nettype none
module vfc_front #(
  parameter int unsigned TAN_TABLE_DEPTH = vfc_pkg::TAN_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vfc_pkg::FOV_W-1:0]   fov_request,
  input  logic [vfc_pkg::DIST_W-1:0]  near_request,
  input  logic [vfc_pkg::DIST_W-1:0]  far_request,
  input  logic                        model_space,
  input  vfc_pkg::cfg_t               cfg,
  input  vfc_pkg::q_status_t          q_status,
  output logic                        push,
  output vfc_pkg::frustum_t           push_data
);
  import vfc_pkg::*;

  localparam int unsigned AW = $clog2(TAN_TABLE_DEPTH + 1);
  localparam int unsigned IW = $clog2(TAN_TABLE_DEPTH) + 1;
  localparam int unsigned PW = FOV_W + AW;
  localparam int unsigned NSTG = 10;
  localparam logic [15:0] SECTOR = 16'd46080;
  localparam logic [22:0] DIV45_MUL = 23'd5965233;

  typedef struct packed {
    logic              model;
    logic [DIST_W-1:0] nd;
    logic [DIST_W-1:0] fd;
  } req_t;

  // floor(v / 45), exact for any 22-bit v
  function automatic logic [16:0] div45(input logic [21:0] v);
    logic [44:0] prod;
    prod = 45'(v) * 45'(DIV45_MUL);
    return prod[44:28];
  endfunction

  logic            en;
  logic [NSTG:1]   vld;
  req_t            req [1:NSTG];
  req_t            req_in;
  logic [FOV_W-1:0] fov0;

  logic [PW-1:0]   p1, p2;
  logic [IW-1:0]   i2;
  logic            sat2;
  logic [15:0]     r3, r4, r5;
  logic            sat3, sat4, sat5, sat6, sat7;
  logic            keep4, keep5, keep6, keep7;
  logic [AW-1:0]   addr_lo, addr_hi;
  logic [31:0]     lo3, hi3, lo4, lo5, lo6, lo7;
  logic [31:0]     d3, d4;
  logic [16:0]     dh4;
  logic [15:0]     dl5;
  logic [32:0]     dhr5, dhr6, dhr7;
  logic [31:0]     x6;
  logic [15:0]     e7;
  logic [TAN_W-1:0] t8;
  logic [HALF_W-1:0] hn9, hf9, hn10, hf10;
  logic [WIDE_W-1:0] wn10, wf10;
  logic [51:0]     hn_prod, hf_prod, wn_prod, wf_prod;

  assign en       = !vld[NSTG] || !q_status.full;
  assign in_ready = en;
  assign push     = vld[NSTG] && !q_status.full;

  assign fov0          = (fov_request == '0) ? cfg.def_fov : fov_request;
  assign req_in.model  = model_space;
  assign req_in.nd     = (near_request == '0) ? cfg.def_near : near_request;
  assign req_in.fd     = (far_request == '0) ? cfg.def_far : far_request;

  assign sat2    = (i2 >= IW'(TAN_TABLE_DEPTH));
  assign addr_lo = sat2 ? '0 : i2[AW-1:0];
  assign addr_hi = addr_lo + AW'(1);
  assign d3      = hi3 - lo3;

  assign hn_prod = 52'(t8) * 52'(req[8].nd) + 52'd32768;
  assign hf_prod = 52'(t8) * 52'(req[8].fd) + 52'd32768;
  assign wn_prod = 52'(hn9) * 52'(cfg.aspect) + 52'd2048;
  assign wf_prod = 52'(hf9) * 52'(cfg.aspect) + 52'd2048;

  vfc_tan_rom #(.DEPTH(TAN_TABLE_DEPTH)) u_rom (
    .clk     (clk),
    .en      (en),
    .addr_lo (addr_lo),
    .addr_hi (addr_hi),
    .data_lo (lo3),
    .data_hi (hi3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req[1] <= req_in;
      for (int k = 2; k <= int'(NSTG); k++) req[k] <= req[k-1];

      p1 <= PW'(fov0) * PW'(TAN_TABLE_DEPTH);

      p2 <= p1;
      i2 <= IW'(div45(22'(p1 >> 10)));

      r3   <= 16'(p2 - PW'(i2) * PW'(SECTOR));
      sat3 <= sat2;

      d4    <= d3;
      dh4   <= div45(22'(d3 >> 10));
      lo4   <= lo3;
      r4    <= r3;
      sat4  <= sat3;
      keep4 <= sat3 || (hi3 <= lo3);

      dl5   <= 16'(d4 - 32'(dh4) * 32'(SECTOR));
      dhr5  <= 33'(dh4) * 33'(r4);
      r5    <= r4;
      lo5   <= lo4;
      sat5  <= sat4;
      keep5 <= keep4;

      x6    <= 32'(dl5) * 32'(r5) + 32'd23040;
      dhr6  <= dhr5;
      lo6   <= lo5;
      sat6  <= sat5;
      keep6 <= keep5;

      e7    <= 16'(div45(22'(x6 >> 10)));
      dhr7  <= dhr6;
      lo7   <= lo6;
      sat7  <= sat6;
      keep7 <= keep6;

      if (sat7) begin
        t8 <= '1;
      end else if (keep7) begin
        t8 <= lo7;
      end else begin
        t8 <= lo7 + dhr7[31:0] + 32'(e7);
      end

      hn9 <= hn_prod[51:16];
      hf9 <= hf_prod[51:16];

      hn10 <= hn9;
      hf10 <= hf9;
      wn10 <= wn_prod[51:12];
      wf10 <= wf_prod[51:12];
    end
  end

  assign push_data.model       = req[NSTG].model;
  assign push_data.dist_center = CEN_W'(req[NSTG].nd) + CEN_W'(req[NSTG].fd);
  assign push_data.dist_near   = req[NSTG].nd;
  assign push_data.dist_far    = req[NSTG].fd;
  assign push_data.half_h_near = hn10;
  assign push_data.half_h_far  = hf10;
  assign push_data.half_w_near = wn10;
  assign push_data.half_w_far  = wf10;
endmodule
`default_nettype wire

[rtl/vfc_queue.sv]
// Two-entry queue of resolved frustum requests between front and back.
`default_nettype none
module vfc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vfc_pkg::frustum_t  push_data,
  input  logic               pop,
  output vfc_pkg::frustum_t  head,
  output vfc_pkg::q_status_t status
);
  import vfc_pkg::*;

  frustum_t    mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end
endmodule
`default_nettype wire

[rtl/vfc_back.sv]
// Back pipeline: walk the nine points, form the vector sums, round and clamp.
`default_nettype none
module vfc_back #(
  parameter int unsigned COORD_BITS = vfc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  vfc_pkg::frustum_t            head,
  input  vfc_pkg::q_status_t           q_status,
  output logic                         pop,
  input  vfc_pkg::cfg_t                cfg,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vfc_pkg::IDX_W-1:0]    point_index,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic                         saturated,
  output logic                         last_point
);
  import vfc_pkg::*;

  localparam logic signed [46:0] HMAX = (47'sd1 <<< (COORD_BITS - 1)) - 47'sd1;
  localparam logic signed [46:0] HMIN = -HMAX - 47'sd1;
  localparam logic signed [VEC_W-1:0] VEC_ONE = 16'sd16384;

  typedef enum logic [1:0] {CORNER_LB, CORNER_RB, CORNER_RT, CORNER_LT} corner_t;

  logic              adv, issue;
  logic [IDX_W-1:0]  cnt;
  corner_t           corner;
  logic              far_plane, up_pos, left_pos;
  logic signed [21:0] d_sel;
  logic signed [37:0] h_sel, h_mag;
  logic signed [41:0] w_sel, w_mag;

  logic signed [VEC_W-1:0] fw [3];
  logic signed [VEC_W-1:0] uv [3];
  logic signed [VEC_W-1:0] lv [3];
  logic signed [POS_W-1:0] pv [3];

  logic                    va;
  logic [IDX_W-1:0]        idx_a;
  logic signed [37:0]      pf [3];
  logic signed [53:0]      pu [3];
  logic signed [57:0]      pl [3];
  logic signed [POS_W-1:0] pos_a [3];

  logic signed [59:0]      acc [3];
  logic signed [44:0]      rnd [3];
  logic signed [46:0]      vsum [3];
  logic signed [COORD_BITS-1:0] comp [3];
  logic [2:0]              clip;

  assign adv   = !out_valid || out_ready;
  assign issue = adv && !q_status.empty;
  assign pop   = issue && (cnt == POINT_LAST);

  assign far_plane = (cnt > 4'd4);
  assign corner    = corner_t'(2'(cnt - 4'd1));

  always_comb begin
    unique case (corner)
      CORNER_LB: begin up_pos = 1'b0; left_pos = 1'b0; end
      CORNER_RB: begin up_pos = 1'b0; left_pos = 1'b1; end
      CORNER_RT: begin up_pos = 1'b1; left_pos = 1'b1; end
      CORNER_LT: begin up_pos = 1'b1; left_pos = 1'b0; end
      default:   begin up_pos = 1'b0; left_pos = 1'b0; end
    endcase
  end

  always_comb begin
    h_mag = $signed({1'b0, (far_plane ? head.half_h_far : head.half_h_near), 1'b0});
    w_mag = $signed({1'b0, (far_plane ? head.half_w_far : head.half_w_near), 1'b0});
    if (cnt == POINT_CENTER) begin
      d_sel = $signed({1'b0, head.dist_center});
      h_sel = '0;
      w_sel = '0;
    end else begin
      d_sel = $signed({1'b0, (far_plane ? head.dist_far : head.dist_near), 1'b0});
      h_sel = up_pos ? h_mag : -h_mag;
      w_sel = left_pos ? w_mag : -w_mag;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (head.model) begin
        fw[a] = (a == 2) ? VEC_ONE : '0;
        uv[a] = (a == 1) ? VEC_ONE : '0;
        lv[a] = (a == 0) ? VEC_ONE : '0;
        pv[a] = '0;
      end else begin
        fw[a] = $signed(cfg.forward[32-16*a +: 16]);
        uv[a] = $signed(cfg.up[32-16*a +: 16]);
        lv[a] = $signed(cfg.left[32-16*a +: 16]);
        pv[a] = $signed(cfg.position[42-21*a +: 21]);
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc[a]  = 60'(pf[a]) + 60'(pu[a]) + 60'(pl[a]);
      rnd[a]  = 45'((acc[a] + 60'sd16384) >>> 15);
      vsum[a] = 47'(rnd[a]) + 47'(pos_a[a]);
      clip[a] = (vsum[a] > HMAX) || (vsum[a] < HMIN);
      if (vsum[a] > HMAX) begin
        comp[a] = COORD_BITS'(HMAX);
      end else if (vsum[a] < HMIN) begin
        comp[a] = COORD_BITS'(HMIN);
      end else begin
        comp[a] = COORD_BITS'(vsum[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= POINT_CENTER;
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va        <= issue;
      out_valid <= va;
      if (issue) cnt <= (cnt == POINT_LAST) ? POINT_CENTER : cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_a <= cnt;
      for (int a = 0; a < 3; a++) begin
        pf[a]    <= 38'(fw[a]) * 38'(d_sel);
        pu[a]    <= 54'(uv[a]) * 54'(h_sel);
        pl[a]    <= 58'(lv[a]) * 58'(w_sel);
        pos_a[a] <= pv[a];
      end
      point_index <= idx_a;
      point_x     <= comp[0];
      point_y     <= comp[1];
      point_z     <= comp[2];
      saturated   <= |clip;
      last_point  <= (idx_a == POINT_LAST);
    end
  end
endmodule
`default_nettype wire
